@@ hdl/gpc_pkg.sv @@
package gpc_pkg;

    localparam int          BOUND_W      = 12;
    localparam int          THR_W        = 13;
    localparam logic [12:0] THR_RESET    = 13'd7;
    localparam logic [7:0]  WHITE_LEVEL  = 8'hFF;
    localparam int          EARLY_WINDOW = 7;
    localparam int          MAX_RES      = 4;
    localparam int          FIFO_DEPTH   = 4;
    localparam int          FIFO_AW      = 2;

    // boundaries caused by one item, packed from index 0 up
    typedef struct packed {
        logic [1:0]                        last_idx;
        logic [MAX_RES-1:0][BOUND_W-1:0]   bound;
    } bundle_t;

endpackage

@@ hdl/gpc_front.sv @@
module gpc_front #(
    parameter int MAX_LEN = 4096
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    input  logic [gpc_pkg::THR_W-1:0]  cfg_data,
    output logic                       cfg_ready,
    input  logic                       in_valid,
    input  logic [7:0]                 in_data,
    input  logic                       in_last,
    output logic                       in_ready,
    input  logic                       queue_full,
    output logic                       push,
    output gpc_pkg::bundle_t           bundle
);

    localparam int POS_W = $clog2(MAX_LEN);
    localparam int RUN_W = POS_W + 1;
    localparam int CMP_W = (RUN_W > gpc_pkg::THR_W) ? RUN_W : gpc_pkg::THR_W;
    localparam int DIF_W = (RUN_W > gpc_pkg::BOUND_W) ? RUN_W : gpc_pkg::BOUND_W;

    logic [gpc_pkg::THR_W-1:0] thr_reg, thr_next;
    logic                      in_white_reg, in_white_next;
    logic [RUN_W-1:0]          run_reg, run_next;
    logic [POS_W-1:0]          pos_reg, pos_next;
    logic                      early_reg, early_next;
    logic                      drop_reg, drop_next;

    logic                      accept;
    logic                      white, last_eff, early, pair;
    logic                      drop_now, drop_en, dropped;
    logic [DIF_W-1:0]          pos_ext, gap_start, tail_start;
    logic [3:0]                vld, keep;
    logic [3:0][gpc_pkg::BOUND_W-1:0] cand;
    logic [2:0]                n;

    assign cfg_ready = 1'b1;
    assign in_ready  = !queue_full;
    assign accept    = in_valid && in_ready;

    always_comb begin
        white    = (in_data == gpc_pkg::WHITE_LEVEL);
        last_eff = in_last || (pos_reg == POS_W'(MAX_LEN - 1));
        early    = !white && (pos_reg < POS_W'(gpc_pkg::EARLY_WINDOW)) && !early_reg;

        pair          = 1'b0;
        in_white_next = in_white_reg;
        if (white == in_white_reg) begin
            run_next = run_reg + 1'b1;
        end else if (white) begin
            run_next      = RUN_W'(1);
            in_white_next = 1'b1;
        end else begin
            pair          = (CMP_W'(run_reg) >= CMP_W'(thr_reg));
            run_next      = RUN_W'(1);
            in_white_next = 1'b0;
        end

        pos_ext    = DIF_W'(pos_reg);
        gap_start  = pos_ext - DIF_W'(run_reg);
        tail_start = pos_ext + DIF_W'(1) - DIF_W'(run_next);
        cand[0] = '0;
        cand[1] = gap_start[gpc_pkg::BOUND_W-1:0];
        cand[2] = pos_ext[gpc_pkg::BOUND_W-1:0];
        cand[3] = white ? tail_start[gpc_pkg::BOUND_W-1:0] : pos_ext[gpc_pkg::BOUND_W-1:0];
        vld     = {last_eff, pair, pair, early};

        // the first boundary of a profile without early ink is swallowed
        drop_now = (pos_reg == '0) || drop_reg;
        drop_en  = drop_now && !early_reg && !early;
        dropped  = 1'b0;
        for (int i = 0; i < 4; i++) begin
            keep[i] = vld[i];
            if (vld[i] && drop_en && !dropped) begin
                keep[i] = 1'b0;
                dropped = 1'b1;
            end
        end

        n            = '0;
        bundle.bound = '0;
        for (int i = 0; i < 4; i++) begin
            if (keep[i]) begin
                bundle.bound[n[1:0]] = cand[i];
                n = n + 3'd1;
            end
        end
        bundle.last_idx = 2'(n - 3'd1);
        push            = accept && (n != '0);

        thr_next = cfg_valid ? cfg_data : thr_reg;
        if (last_eff) begin
            pos_next      = '0;
            in_white_next = 1'b1;
            run_next      = '0;
            early_next    = 1'b0;
            drop_next     = 1'b0;
        end else begin
            pos_next   = pos_reg + 1'b1;
            early_next = early_reg || early;
            drop_next  = drop_now && !dropped;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg      <= gpc_pkg::THR_RESET;
            in_white_reg <= 1'b1;
            run_reg      <= '0;
            pos_reg      <= '0;
            early_reg    <= 1'b0;
            drop_reg     <= 1'b0;
        end else begin
            thr_reg <= thr_next;
            if (accept) begin
                in_white_reg <= in_white_next;
                run_reg      <= run_next;
                pos_reg      <= pos_next;
                early_reg    <= early_next;
                drop_reg     <= drop_next;
            end
        end
    end

endmodule

@@ hdl/gpc_fifo.sv @@
module gpc_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  gpc_pkg::bundle_t wr_bundle,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output gpc_pkg::bundle_t rd_bundle
);

    gpc_pkg::bundle_t                  mem_reg [gpc_pkg::FIFO_DEPTH];
    logic [gpc_pkg::FIFO_AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [gpc_pkg::FIFO_AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [gpc_pkg::FIFO_AW:0]         count_reg, count_next;

    assign full      = (count_reg == (gpc_pkg::FIFO_AW + 1)'(gpc_pkg::FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_bundle = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (gpc_pkg::FIFO_AW + 1)'(push)
                                - (gpc_pkg::FIFO_AW + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_bundle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full) else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty) else $error("queue read while empty");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0 && count_reg != (gpc_pkg::FIFO_AW + 1)'(gpc_pkg::FIFO_DEPTH))
        |-> (wr_ptr_reg != rd_ptr_reg)) else $error("pointers disagree with fill count");

endmodule

@@ hdl/gpc_back.sv @@
module gpc_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             not_empty,
    input  gpc_pkg::bundle_t head,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,
    output logic             m_tlast
);

    logic [1:0] idx_reg, idx_next;
    logic       take;

    assign m_tvalid = not_empty;
    assign m_tdata  = {{(16 - gpc_pkg::BOUND_W){1'b0}}, head.bound[idx_reg]};
    assign m_tlast  = (idx_reg == head.last_idx);
    assign take     = m_tvalid && m_tready;
    assign pop      = take && m_tlast;

    always_comb begin
        idx_next = idx_reg;
        if (take) begin
            idx_next = m_tlast ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else begin
            idx_reg <= idx_next;
        end
    end

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (idx_reg <= head.last_idx)) else $error("read past end of bundle");

    a_idx_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (idx_reg == 2'd0)) else $error("index not cleared after bundle");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(idx_reg)) else $error("index moved on stall");

endmodule

@@ hdl/projection_gap_cutter_top.sv @@
// Projection gap cutter: splits a projection profile at wide white gaps.
// Input stream (s_*): one profile value per item in s_tdata[7:0], s_tlast
// on the final value of the profile. A value of 255 is white.
// Output stream (m_*): boundary positions in m_tdata[11:0], ascending;
// m_tlast marks the final boundary caused by one input item.
// Config channel (cfg_*): gap threshold, 13 bits, reset value 7. Write only
// while the block is idle; cfg_ready is always high.
// Each input item is classified combinationally as it is taken; its up to
// four boundaries are pushed as one entry into a four-entry queue. The
// first boundary of an item can appear on m_* in the cycle after the item
// is taken. Input rate is one item per cycle while s_tready is high; the
// output side moves one boundary per cycle while m_tready is high, so
// items with several boundaries fill the queue. s_tready drops only while
// all four entries are occupied, e.g. when m_tready is held low.
// A profile ends on s_tlast or after MAX_LEN values, whichever comes first.
// Reset (aresetn low, synchronous) empties the queue, restores the
// threshold to 7 and starts a fresh profile.
module projection_gap_cutter_top #(
    parameter int MAX_LEN = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] profile_value
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [11:0] boundary, [15:12] zero
    output logic        m_tlast
);

    gpc_pkg::bundle_t wr_bundle, rd_bundle;
    logic             push, pop, full, not_empty;

    gpc_front #(.MAX_LEN(MAX_LEN)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .cfg_ready  (cfg_ready),
        .in_valid   (s_tvalid),
        .in_data    (s_tdata),
        .in_last    (s_tlast),
        .in_ready   (s_tready),
        .queue_full (full),
        .push       (push),
        .bundle     (wr_bundle)
    );

    gpc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .wr_bundle (wr_bundle),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .rd_bundle (rd_bundle)
    );

    gpc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .not_empty (not_empty),
        .head      (rd_bundle),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

@@ tb/sv/tb_projection_gap_cutter_top.sv @@
`timescale 1ns / 100ps

module tb_projection_gap_cutter_top;

    localparam int PROFILE_MAX = 4096;
    localparam int IDLE_PCT    = 26;
    localparam int HOLD_CYCLES = 80;

    typedef struct {
        logic [gpc_pkg::BOUND_W-1:0] bound;
        logic                        last;
    } boundary_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [12:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;    // [7:0] profile_value
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;           // [11:0] boundary, [15:12] zero
    logic        m_tlast;

    // predictor state, tracks the block item by item
    logic [gpc_pkg::THR_W-1:0]   threshold    = gpc_pkg::THR_RESET;
    logic                        in_white     = 1'b1;
    logic [12:0]                 run_len      = '0;
    logic [12:0]                 prof_pos     = '0;
    logic                        early_ink    = 1'b0;
    logic                        drop_pending = 1'b0;
    logic [gpc_pkg::BOUND_W-1:0] step_bounds [gpc_pkg::MAX_RES];
    int                          step_count;

    boundary_t boundary_q [$];
    int        errors        = 0;
    logic      no_idle       = 1'b0;
    int        stall_reqs    = 0;
    int        stalls_served = 0;
    int        stall_left    = 0;

    projection_gap_cutter_top #(
        .MAX_LEN (PROFILE_MAX)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // first boundary of a profile without early ink is swallowed
    function automatic void take_boundary(input logic [12:0] pos);
        if (!early_ink && drop_pending) begin
            drop_pending = 1'b0;
        end else if (step_count < gpc_pkg::MAX_RES) begin
            step_bounds[step_count] = pos[gpc_pkg::BOUND_W-1:0];
            step_count++;
        end
    endfunction

    function automatic void predict_boundaries(input logic [7:0] value, input logic last_in);
        logic      white;
        logic      ends;
        boundary_t nxt_b;
        white = (value == gpc_pkg::WHITE_LEVEL);
        ends  = last_in || (prof_pos >= PROFILE_MAX - 1);
        step_count = 0;
        if (prof_pos == 0)
            drop_pending = 1'b1;
        if (!white && prof_pos < gpc_pkg::EARLY_WINDOW && !early_ink) begin
            early_ink = 1'b1;
            take_boundary(13'd0);
        end
        if (white == in_white) begin
            run_len++;
        end else if (white) begin
            run_len  = 13'd1;
            in_white = 1'b1;
        end else begin
            if (run_len >= threshold) begin
                take_boundary(prof_pos - run_len);
                take_boundary(prof_pos);
            end
            run_len  = 13'd1;
            in_white = 1'b0;
        end
        if (ends) begin
            if (white)
                take_boundary(prof_pos + 13'd1 - run_len);
            else
                take_boundary(prof_pos);
            in_white     = 1'b1;
            run_len      = '0;
            prof_pos     = '0;
            early_ink    = 1'b0;
            drop_pending = 1'b0;
        end else begin
            prof_pos++;
        end
        for (int k = 0; k < step_count; k++) begin
            nxt_b.bound = step_bounds[k];
            nxt_b.last  = (k == step_count - 1);
            boundary_q.insert(boundary_q.size(), nxt_b);
        end
    endfunction

    // output side: checks each boundary, stalls at random or on request
    always @(posedge aclk) begin
        boundary_t exp_b;
        if (aresetn && m_tvalid && m_tready) begin
            if (boundary_q.size() == 0) begin
                $display("%0t: unexpected boundary, expected none, actual %h last %b",
                         $time, m_tdata, m_tlast);
                errors++;
            end else begin
                exp_b = boundary_q.pop_front();
                if (m_tdata !== {4'b0, exp_b.bound} || m_tlast !== exp_b.last) begin
                    $display("%0t: boundary mismatch, expected %h last %b, actual %h last %b",
                             $time, {4'b0, exp_b.bound}, exp_b.last, m_tdata, m_tlast);
                    errors++;
                end
            end
        end
        if (stall_reqs != stalls_served) begin
            stalls_served <= stalls_served + 1;
            stall_left    <= HOLD_CYCLES;
            m_tready      <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic send_value(input logic [7:0] value, input logic last_in);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last_in;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_boundaries(value, last_in);
    endtask

    // alternating white and ink runs, with the odd stray value
    task automatic send_profile(input int len, input bit closed);
        logic       white;
        int         run_left;
        logic [7:0] value;
        white    = 1'($urandom_range(1));
        run_left = $urandom_range(1, 10);
        for (int i = 0; i < len; i++) begin
            if (run_left == 0) begin
                white    = !white;
                run_left = white ? $urandom_range(1, 12) : $urandom_range(1, 6);
            end
            value = white ? gpc_pkg::WHITE_LEVEL : 8'($urandom_range(254));
            if ($urandom_range(15) == 0)
                value = 8'($urandom_range(255));
            send_value(value, closed && (i == len - 1));
            run_left--;
        end
    endtask

    task automatic write_threshold(input logic [12:0] value);
        s_tvalid <= 1'b0;
        while (boundary_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        threshold = value;
    endtask

    // early ink gives a leading 0, a gap of exactly the threshold, ink at the end
    task automatic test_early_ink_profile();
        send_value(8'h00, 1'b0);
        repeat (7) send_value(gpc_pkg::WHITE_LEVEL, 1'b0);
        send_value(8'hFE, 1'b0);
        send_value(8'h80, 1'b1);
    endtask

    // all-white start: first boundary is dropped, trailing white run reported
    task automatic test_dropped_first_boundary();
        repeat (7) send_value(gpc_pkg::WHITE_LEVEL, 1'b0);
        send_value(8'h01, 1'b0);
        send_value(gpc_pkg::WHITE_LEVEL, 1'b1);
    endtask

    // threshold zero: every white-to-ink change splits, up to four per item
    task automatic test_zero_threshold();
        write_threshold(13'd0);
        send_value(8'h00, 1'b1);
        send_value(gpc_pkg::WHITE_LEVEL, 1'b0);
        send_value(8'h00, 1'b0);
        send_value(gpc_pkg::WHITE_LEVEL, 1'b1);
    endtask

    task automatic test_pressure();
        write_threshold(13'd1);
        no_idle    <= 1'b1;
        stall_reqs <= stall_reqs + 1;
        for (int i = 0; i < 24; i++)
            send_value((i % 2) ? 8'h00 : gpc_pkg::WHITE_LEVEL, i == 23);
        no_idle <= 1'b0;
    endtask

    task automatic test_random_profiles();
        logic [12:0] thr_list [7];
        int          sent;
        int          len;
        thr_list = '{13'd1, 13'd2, 13'd4096, 13'd0, 13'd8191, 13'd7, 13'd3};
        for (int ph = 0; ph < 7; ph++) begin
            if (ph == 6)
                thr_list[ph] = 13'($urandom_range(3, 12));
            write_threshold(thr_list[ph]);
            no_idle <= (ph == 3);
            sent = 0;
            while (sent < 14) begin
                len = ($urandom_range(7) == 0) ? 1 : $urandom_range(2, 24);
                send_profile(len, 1'b1);
                sent += len;
            end
        end
        no_idle <= 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_early_ink_profile();
        test_dropped_first_boundary();
        test_zero_threshold();
        test_pressure();
        test_random_profiles();
        s_tvalid <= 1'b0;
        for (int w = 0; w < 20000 && boundary_q.size() != 0; w++)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (boundary_q.size() != 0) begin
            $display("%0t: %0d boundaries never arrived, next expected %h",
                     $time, boundary_q.size(), boundary_q[0].bound);
            errors++;
        end
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("%0t: timeout", $time);
        $display("simulation failed");
        $finish;
    end

endmodule
